/* src/lrut_pkg.sv */
// Shared constants for the LRU replacement tracker.
package lrut_pkg;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

endpackage

/* src/lrut_if.sv */
// Handshake channel interfaces for the LRU replacement tracker.
interface lrut_req_if #(
  parameter int ADDR_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface lrut_rsp_if #(
  parameter int ADDR_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 evicted_valid;
  logic [ADDR_BITS-1:0] evicted_address;

  modport source (output valid, output hit, output evicted_valid, output evicted_address,
                  input ready);
  modport sink   (input valid, input hit, input evicted_valid, input evicted_address,
                  output ready);
endinterface

/* src/lru_replacement_tracker_unit.sv */
// Top level of the fully associative LRU replacement tracker.
//
//   channel   direction  handshake              payload
//   in_req    in         valid/ready            address
//   out_rsp   out        valid/ready            hit, evicted_valid, evicted_address
//   cfg_*     in         cfg_we, no ready       cfg_wdata (capacity)
//
// Each access beat is held in an input register; from there the
// parallel compare and recency update run and the result is registered.
// A beat can be taken every cycle while the result is not stalled.
// A stalled result holds the pipeline; the input register still takes one beat.
// Reset clears all entries, the recency ranks and the count, and sets the capacity to 16.
module lru_replacement_tracker_unit
  import lrut_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int ADDR_BITS   = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  lrut_req_if.sink         in_req,
  lrut_rsp_if.source       out_rsp
);

  localparam int RANK_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]     cfg_r;
  logic                 req_valid_r;
  logic [ADDR_BITS-1:0] req_addr_r;
  logic [ADDR_BITS-1:0] addr_r [MAX_ENTRIES];
  logic [RANK_W-1:0]    rank_r [MAX_ENTRIES];
  logic [RANK_W-1:0]    rank_nxt [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r;
  logic [MAX_ENTRIES-1:0] valid_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 out_valid_r;
  logic                 hit_r;
  logic                 ev_valid_r;
  logic [ADDR_BITS-1:0] ev_addr_r;

  logic                   adv;
  logic [CMP_W-1:0]       cfg_ext;
  logic [CMP_W-1:0]       cap;
  logic                   need_evict;
  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [MAX_ENTRIES-1:0] lru_vec;
  logic [MAX_ENTRIES-1:0] free_first;
  logic [MAX_ENTRIES-1:0] victim_oh;
  logic                   hit;
  logic [RANK_W-1:0]      hit_rank;
  logic [RANK_W-1:0]      lru_rank;
  logic [ADDR_BITS-1:0]   lru_addr;

  assign adv           = req_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready  = !req_valid_r || adv;

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.hit             = hit_r;
  assign out_rsp.evicted_valid   = ev_valid_r;
  assign out_rsp.evicted_address = ev_addr_r;

  // A capacity of zero counts as one; anything above the built depth saturates.
  assign cfg_ext = CMP_W'(cfg_r);
  always_comb begin
    if (cfg_r == '0) begin
      cap = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_ENTRIES)) begin
      cap = CMP_W'(MAX_ENTRIES);
    end else begin
      cap = cfg_ext;
    end
  end

  assign need_evict = CMP_W'(count_r) >= cap;
  assign lru_rank   = RANK_W'(count_r - CNT_W'(1));
  assign free_first = ~valid_r & (valid_r + MAX_ENTRIES'(1));
  assign hit        = |hit_vec;
  assign victim_oh  = need_evict ? lru_vec : free_first;

  // The valid entries always hold each rank below the count exactly once,
  // so the least recent entry is the one whose rank is the count less one.
  always_comb begin
    hit_rank = '0;
    lru_addr = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (addr_r[i] == req_addr_r);
      lru_vec[i] = valid_r[i] && (rank_r[i] == lru_rank);
      if (hit_vec[i]) begin
        hit_rank = hit_rank | rank_r[i];
      end
      if (lru_vec[i]) begin
        lru_addr = lru_addr | addr_r[i];
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (hit) begin
        if (hit_vec[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end else if (victim_oh[i]) begin
        rank_nxt[i]  = '0;
        valid_nxt[i] = 1'b1;
      end else if (valid_r[i]) begin
        rank_nxt[i] = rank_r[i] + RANK_W'(1);
      end
    end
    if (!hit && !need_evict) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (in_req.valid && in_req.ready) begin
        req_valid_r <= 1'b1;
      end else if (adv) begin
        req_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        valid_r     <= valid_nxt;
        count_r     <= count_nxt;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_addr_r <= in_req.address;
    end
    if (adv) begin
      hit_r      <= hit;
      ev_valid_r <= !hit && need_evict;
      ev_addr_r  <= (!hit && need_evict) ? lru_addr : '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (!hit && victim_oh[i]) begin
          addr_r[i] <= req_addr_r;
        end
      end
    end
  end

endmodule

/* sim/tb.sv */
// Self-checking testbench for the LRU replacement tracker, with its own prediction of each result.
module tb;
  import lrut_pkg::*;

  localparam int ADDR_W = 32;
  localparam int DEPTH = 16;
  localparam int CAP_MAX = 16;
  localparam int SETTLE_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic              hit;
    logic              evicted_valid;
    logic [ADDR_W-1:0] evicted_address;
  } access_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  lrut_req_if #(.ADDR_BITS(ADDR_W)) in_req ();
  lrut_rsp_if #(.ADDR_BITS(ADDR_W)) out_rsp ();

  lru_replacement_tracker_unit #(
    .MAX_ENTRIES(DEPTH),
    .ADDR_BITS  (ADDR_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_req   (in_req),
    .out_rsp  (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the tracker contents; rank 0 is the most recently used line.
  logic [ADDR_W-1:0] line_addr [DEPTH];
  logic              line_valid[DEPTH];
  int                line_rank [DEPTH];
  int                live_lines;
  logic [CFG_W-1:0]  capacity_reg;

  access_result_t    expected_results[$];
  logic [ADDR_W-1:0] addr_pool[$];
  int                send_idle_pct;
  int                recv_idle_pct;
  int                mismatch_count;
  int                quiet_cycles;

  function automatic void clear_tracker_model();
    for (int i = 0; i < DEPTH; i++) begin
      line_addr[i] = '0;
      line_valid[i] = 1'b0;
      line_rank[i] = 0;
    end
    live_lines = 0;
    capacity_reg = CFG_RESET;
  endfunction

  function automatic access_result_t lookup_and_replace(input logic [ADDR_W-1:0] addr);
    access_result_t res;
    int slot;
    int oldest;
    int cap;
    res = '0;
    slot = -1;
    oldest = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot < 0 && line_valid[i] && line_addr[i] == addr) slot = i;
    end
    if (slot >= 0) begin
      res.hit = 1'b1;
      for (int i = 0; i < DEPTH; i++) begin
        if (line_valid[i] && line_rank[i] < line_rank[slot]) line_rank[i]++;
      end
      line_rank[slot] = 0;
      return res;
    end
    cap = (capacity_reg == 0) ? 1 : ((capacity_reg > CAP_MAX) ? CAP_MAX : int'(capacity_reg));
    if (live_lines >= cap) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (line_valid[i] && (slot < 0 || line_rank[i] > oldest)) begin
          slot = i;
          oldest = line_rank[i];
        end
      end
    end
    if (slot >= 0) begin
      res.evicted_valid = 1'b1;
      res.evicted_address = line_addr[slot];
      line_valid[slot] = 1'b0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (slot < 0 && !line_valid[i]) slot = i;
      end
      if (slot < 0) slot = 0;
      else live_lines++;
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (line_valid[i]) line_rank[i]++;
    end
    line_valid[slot] = 1'b1;
    line_addr[slot] = addr;
    line_rank[slot] = 0;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic send_access(input logic [ADDR_W-1:0] addr);
    if ($urandom_range(99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_req.valid <= 1'b1;
    in_req.address <= addr;
    do @(posedge clk); while (!in_req.ready);
    expected_results.push_back(lookup_and_replace(addr));
  endtask

  task automatic drain_tracker();
    in_req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity_reg = value;
  endtask

  task automatic test_fill_and_hit();
    send_access(32'h0000_0000);
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    send_access(32'h8000_0000);
    send_access(32'h0000_0001);
    send_access(32'hFFFF_FFFF);
    send_access(32'h0000_0000);
  endtask

  task automatic test_capacity_lowered();
    drain_tracker();
    write_capacity(CFG_W'(2));
    send_access(32'h1234_5678);
    send_access(32'h9ABC_DEF0);
    send_access(32'h1234_5678);
  endtask

  task automatic test_capacity_zero();
    drain_tracker();
    write_capacity('0);
    send_access(32'hA5A5_A5A5);
    send_access(32'h5A5A_5A5A);
    send_access(32'h5A5A_5A5A);
  endtask

  task automatic test_capacity_saturated();
    drain_tracker();
    write_capacity('1);
    for (int i = 0; i < 13; i++) send_access(32'hC000_0000 | ADDR_W'(i));
  endtask

  task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
                                     input int accesses);
    int sent;
    int pick;
    logic [CFG_W-1:0] cap;
    logic [ADDR_W-1:0] addr;
    sent = 0;
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    while (sent < accesses) begin
      drain_tracker();
      case ($urandom_range(4))
        0: cap = '0;
        1: cap = CFG_W'(1);
        2: cap = CFG_W'(CAP_MAX);
        3: cap = '1;
        default: cap = CFG_W'($urandom_range(31));
      endcase
      write_capacity(cap);
      // A small working set keeps hits and evictions both frequent.
      addr_pool.delete();
      repeat ($urandom_range(1, 22)) addr_pool.push_back(ADDR_W'($urandom));
      repeat (60) begin
        pick = $urandom_range(99);
        addr = addr_pool[$urandom_range(addr_pool.size() - 1)];
        if (pick >= 93) addr = ADDR_W'($urandom);
        else if (pick >= 85) addr = addr ^ (ADDR_W'(1) << $urandom_range(ADDR_W - 1));
        send_access(addr);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    out_rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : result_checker
    access_result_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with no access outstanding");
      end else begin
        want = expected_results.pop_front();
        if (out_rsp.hit !== want.hit)
          report_mismatch($sformatf("hit %b, expected %b", out_rsp.hit, want.hit));
        if (out_rsp.evicted_valid !== want.evicted_valid)
          report_mismatch($sformatf("evicted_valid %b, expected %b",
                                    out_rsp.evicted_valid, want.evicted_valid));
        if (out_rsp.evicted_address !== want.evicted_address)
          report_mismatch($sformatf("evicted_address %h, expected %h",
                                    out_rsp.evicted_address, want.evicted_address));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_req.valid = 1'b0;
    in_req.address = '0;
    out_rsp.ready = 1'b0;
    mismatch_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 38;
    recv_idle_pct = 84;
    clear_tracker_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_and_hit();
    test_capacity_lowered();
    test_capacity_zero();
    test_capacity_saturated();
    test_random_traffic(38, 84, 560);
    test_random_traffic(84, 38, 560);
    test_random_traffic(0, 0, 600);

    drain_tracker();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/lrut_pkg.sv
src/lrut_if.sv
src/lru_replacement_tracker_unit.sv
sim/tb.sv
